### rtl/chol_pkg.sv
`timescale 1ns / 1ps
// shared types and helpers for the cholesky factorisation block
// no dependencies

package chol_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_W = 16;
	localparam int CFG_W  = 4;

	typedef enum logic [4:0] {
		S_LOAD, S_FILL, S_ACC_RD, S_ACC_LD, S_A_RD, S_B_RD, S_MUL, S_SCALE, S_SUB,
		S_PIVOT, S_DIV_LD, S_DIV_W, S_SQRT_W, S_NEXT, S_OUT_RD, S_OUT_LD, S_ERR
	} chol_state_t;

	typedef enum logic [1:0] {
		WSEL_IN, WSEL_ZERO, WSEL_DIV, WSEL_SQRT
	} chol_wsel_t;

	typedef struct packed {
		logic       rd_en;
		logic       wr_en;
		chol_wsel_t wr_sel;
		logic       ld_acc;
		logic       ld_a;
		logic       mul;
		logic       scale;
		logic       sub;
		logic       start_div;
		logic       start_sqrt;
		logic       load_out;
		logic       out_err;
		logic       out_last;
	} chol_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic acc_nonpos;
		logic out_free;
	} chol_status_t;

	// triangular number: base slot of a row in row-major lower order
	function automatic int tri_num(input int m);
		return (m * (m + 1)) / 2;
	endfunction

endpackage

### rtl/chol_div.sv
`timescale 1ns / 1ps
// iterative restoring divider: (num * 2^16) / den, truncating, saturated
// depends on chol_pkg

module chol_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [chol_pkg::WORD_W-1:0] num,
	input  logic signed [chol_pkg::WORD_W-1:0] den,
	output logic                               done,
	output logic signed [chol_pkg::WORD_W-1:0] quot
);

	localparam int DIVD_W = chol_pkg::WORD_W + chol_pkg::FRAC_W;
	localparam int CNT_W  = $clog2(DIVD_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [31:0]           rem_q;
	logic [DIVD_W-1:0]     quo_q;
	logic [31:0]           den_q;
	logic                  neg_q;
	logic                  zero_q;
	logic signed [31:0]    res_q;
	logic [31:0]           num_mag;
	logic [32:0]           shifted;
	logic                  qbit;
	logic signed [31:0]    res_d;

	assign num_mag = num[31] ? 32'(-num) : 32'(num);
	assign shifted = {rem_q, quo_q[DIVD_W-1]};
	assign qbit    = (shifted >= {1'b0, den_q});

	always_comb begin
		if (zero_q) begin
			res_d = '0;
		end else if (neg_q) begin
			if (quo_q > DIVD_W'(33'h0_8000_0000)) res_d = 32'sh8000_0000;
			else res_d = 32'(-quo_q);
		end else begin
			if (quo_q > DIVD_W'(32'h7FFF_FFFF)) res_d = 32'sh7FFF_FFFF;
			else res_d = 32'(quo_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVD_W);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= {num_mag, {chol_pkg::FRAC_W{1'b0}}};
			den_q  <= den;
			neg_q  <= num[31];
			zero_q <= den[31] || (den == '0);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				rem_q <= qbit ? 32'(shifted - {1'b0, den_q}) : shifted[31:0];
				quo_q <= {quo_q[DIVD_W-2:0], qbit};
			end else begin
				res_q <= res_d;
			end
		end
	end

	assign done = done_q;
	assign quot = res_q;

endmodule

### rtl/chol_sqrt.sv
`timescale 1ns / 1ps
// iterative integer square root of v * 2^16, two bits a cycle
// depends on chol_pkg

module chol_sqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [chol_pkg::WORD_W-1:0] val,
	output logic                               done,
	output logic signed [chol_pkg::WORD_W-1:0] root
);

	localparam int X_W = chol_pkg::WORD_W + chol_pkg::FRAC_W;

	logic           busy_q;
	logic           done_q;
	logic [X_W-1:0] x_q;
	logic [X_W-1:0] res_q;
	logic [X_W-1:0] bit_q;
	logic [X_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == X_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= {val, {chol_pkg::FRAC_W{1'b0}}};
			res_q <= '0;
			bit_q <= X_W'(1) << (X_W - 2);
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[chol_pkg::WORD_W-1:0];

endmodule

### rtl/chol_dp.sv
`timescale 1ns / 1ps
// datapath: triangle store, multiply-subtract chain, divider, root, result register
// depends on chol_pkg, chol_div, chol_sqrt

module chol_dp #(
	parameter int MAX_ORDER = 8
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  chol_pkg::chol_cmd_t                                  cmd,
	input  logic [(MAX_ORDER*(MAX_ORDER+1)/2 > 1 ? $clog2(MAX_ORDER*(MAX_ORDER+1)/2) : 1)-1:0] rd_addr,
	input  logic [(MAX_ORDER*(MAX_ORDER+1)/2 > 1 ? $clog2(MAX_ORDER*(MAX_ORDER+1)/2) : 1)-1:0] wr_addr,
	input  logic signed [chol_pkg::WORD_W-1:0]                   element_value,
	input  logic                                                 out_stall,
	output chol_pkg::chol_status_t                               status,
	output logic                                                 out_valid,
	output logic signed [chol_pkg::WORD_W-1:0]                   factor_value,
	output logic                                                 not_positive_definite,
	output logic                                                 last_result
);

	localparam int SLOTS  = MAX_ORDER * (MAX_ORDER + 1) / 2;

	logic signed [31:0] mem [SLOTS];
	logic signed [31:0] rdata_q;
	logic signed [31:0] acc_q;
	logic signed [31:0] a_q;
	logic signed [63:0] prod_s1;
	logic signed [31:0] term_s2;
	logic signed [63:0] shifted;
	logic signed [32:0] diff;
	logic signed [31:0] wr_data;
	logic signed [31:0] div_res;
	logic signed [31:0] sqrt_res;
	logic               div_done;
	logic               sqrt_done;
	logic               out_valid_q;
	logic signed [31:0] factor_q;
	logic               err_q;
	logic               last_q;

	chol_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_div),
		.num    (acc_q),
		.den    (rdata_q),
		.done   (div_done),
		.quot   (div_res)
	);

	chol_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_sqrt),
		.val    (acc_q),
		.done   (sqrt_done),
		.root   (sqrt_res)
	);

	always_comb begin
		case (cmd.wr_sel)
			chol_pkg::WSEL_IN:   wr_data = element_value;
			chol_pkg::WSEL_ZERO: wr_data = '0;
			chol_pkg::WSEL_DIV:  wr_data = div_res;
			chol_pkg::WSEL_SQRT: wr_data = sqrt_res;
			default:             wr_data = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd_en) rdata_q <= mem[rd_addr];
	end

	// truncate toward zero: arithmetic shift, then round negatives up
	always_comb begin
		shifted = prod_s1 >>> chol_pkg::FRAC_W;
		if (prod_s1[63] && prod_s1[15:0] != '0) shifted = shifted + 64'sd1;
	end

	assign diff = 33'(acc_q) - 33'(term_s2);

	always_ff @(posedge clk) begin
		if (cmd.ld_acc) begin
			acc_q <= rdata_q;
		end else if (cmd.sub) begin
			if (diff > 33'sh0_7FFF_FFFF) acc_q <= 32'sh7FFF_FFFF;
			else if (diff < -33'sh0_8000_0000) acc_q <= 32'sh8000_0000;
			else acc_q <= diff[31:0];
		end
		if (cmd.ld_a) a_q <= rdata_q;
		if (cmd.mul) prod_s1 <= a_q * rdata_q;
		if (cmd.scale) begin
			if (shifted > 64'sh7FFF_FFFF) term_s2 <= 32'sh7FFF_FFFF;
			else if (shifted < -64'sh8000_0000) term_s2 <= 32'sh8000_0000;
			else term_s2 <= shifted[31:0];
		end
	end

	// result register parts the store from the output channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			factor_q <= cmd.out_err ? 32'sd0 : rdata_q;
			err_q    <= cmd.out_err;
			last_q   <= cmd.out_last;
		end
	end

	assign status.div_done   = div_done;
	assign status.sqrt_done  = sqrt_done;
	assign status.acc_nonpos = acc_q[31] || (acc_q == '0);
	assign status.out_free   = !out_valid_q || !out_stall;

	assign out_valid             = out_valid_q;
	assign factor_value          = factor_q;
	assign not_positive_definite = err_q;
	assign last_result           = last_q;

endmodule

### rtl/chol_ctrl.sv
`timescale 1ns / 1ps
// controller: load sequencing, factorisation loop counters, result sweep
// depends on chol_pkg

module chol_ctrl #(
	parameter int MAX_ORDER = 8
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 cfg_valid,
	input  logic [chol_pkg::CFG_W-1:0]                           cfg_data,
	input  logic                                                 in_valid,
	input  logic                                                 last_element,
	output logic                                                 in_stall,
	input  chol_pkg::chol_status_t                               status,
	output chol_pkg::chol_cmd_t                                  cmd,
	output logic [(MAX_ORDER*(MAX_ORDER+1)/2 > 1 ? $clog2(MAX_ORDER*(MAX_ORDER+1)/2) : 1)-1:0] rd_addr,
	output logic [(MAX_ORDER*(MAX_ORDER+1)/2 > 1 ? $clog2(MAX_ORDER*(MAX_ORDER+1)/2) : 1)-1:0] wr_addr
);

	localparam int SLOTS  = MAX_ORDER * (MAX_ORDER + 1) / 2;
	localparam int ADDR_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int ORD_W  = $clog2(MAX_ORDER + 1);

	chol_pkg::chol_state_t state_q, state_d;

	logic [chol_pkg::CFG_W-1:0] msize_q;
	logic [CNT_W-1:0]           load_count_q;
	logic [CNT_W-1:0]           ptr_q;
	logic [ORD_W-1:0]           i_q, j_q, k_q;
	logic [ORD_W-1:0]           n;
	logic [CNT_W-1:0]           total;
	logic [CNT_W-1:0]           count_next;
	logic                       accept;
	logic                       room;
	int                         ri, rj;

	assign accept = in_valid && (state_q == chol_pkg::S_LOAD);
	assign room   = int'(load_count_q) < SLOTS;
	assign count_next = room ? load_count_q + 1'b1 : load_count_q;

	always_comb begin
		if (msize_q == '0) n = ORD_W'(1);
		else if (int'(msize_q) > MAX_ORDER) n = ORD_W'(MAX_ORDER);
		else n = ORD_W'(msize_q);
	end

	assign total = CNT_W'(chol_pkg::tri_num(int'(n)));
	assign ri    = chol_pkg::tri_num(int'(i_q));
	assign rj    = chol_pkg::tri_num(int'(j_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= chol_pkg::S_LOAD;
			msize_q      <= chol_pkg::CFG_W'(MAX_ORDER);
			load_count_q <= '0;
			ptr_q        <= '0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) msize_q <= cfg_data;
			case (state_q)
				chol_pkg::S_LOAD: begin
					if (accept) begin
						if (last_element) begin
							ptr_q        <= count_next;
							load_count_q <= '0;
						end else begin
							load_count_q <= count_next;
						end
					end
				end
				chol_pkg::S_FILL: begin
					if (ptr_q < total) begin
						ptr_q <= ptr_q + 1'b1;
					end else begin
						i_q <= '0;
						j_q <= '0;
					end
				end
				chol_pkg::S_ACC_RD: k_q <= '0;
				chol_pkg::S_SUB:    k_q <= k_q + 1'b1;
				chol_pkg::S_NEXT: begin
					if (j_q < i_q) begin
						j_q <= j_q + 1'b1;
					end else if (int'(i_q) + 1 < int'(n)) begin
						i_q <= i_q + 1'b1;
						j_q <= '0;
					end else begin
						ptr_q <= '0;
					end
				end
				chol_pkg::S_OUT_LD: begin
					if (status.out_free) ptr_q <= ptr_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			chol_pkg::S_LOAD: begin
				if (accept && last_element) state_d = chol_pkg::S_FILL;
			end
			chol_pkg::S_FILL: begin
				if (ptr_q >= total) state_d = chol_pkg::S_ACC_RD;
			end
			chol_pkg::S_ACC_RD: state_d = chol_pkg::S_ACC_LD;
			chol_pkg::S_ACC_LD: begin
				state_d = (k_q < j_q) ? chol_pkg::S_A_RD : chol_pkg::S_PIVOT;
			end
			chol_pkg::S_A_RD:  state_d = chol_pkg::S_B_RD;
			chol_pkg::S_B_RD:  state_d = chol_pkg::S_MUL;
			chol_pkg::S_MUL:   state_d = chol_pkg::S_SCALE;
			chol_pkg::S_SCALE: state_d = chol_pkg::S_SUB;
			chol_pkg::S_SUB: begin
				state_d = (int'(k_q) + 1 < int'(j_q)) ? chol_pkg::S_A_RD : chol_pkg::S_PIVOT;
			end
			chol_pkg::S_PIVOT: begin
				if (j_q < i_q) state_d = chol_pkg::S_DIV_LD;
				else if (status.acc_nonpos) state_d = chol_pkg::S_ERR;
				else state_d = chol_pkg::S_SQRT_W;
			end
			chol_pkg::S_DIV_LD: state_d = chol_pkg::S_DIV_W;
			chol_pkg::S_DIV_W: begin
				if (status.div_done) state_d = chol_pkg::S_NEXT;
			end
			chol_pkg::S_SQRT_W: begin
				if (status.sqrt_done) state_d = chol_pkg::S_NEXT;
			end
			chol_pkg::S_NEXT: begin
				if (j_q < i_q || int'(i_q) + 1 < int'(n)) state_d = chol_pkg::S_ACC_RD;
				else state_d = chol_pkg::S_OUT_RD;
			end
			chol_pkg::S_OUT_RD: state_d = chol_pkg::S_OUT_LD;
			chol_pkg::S_OUT_LD: begin
				if (status.out_free) begin
					state_d = (ptr_q + 1'b1 == total) ? chol_pkg::S_LOAD : chol_pkg::S_OUT_RD;
				end
			end
			chol_pkg::S_ERR: begin
				if (status.out_free) state_d = chol_pkg::S_LOAD;
			end
			default: state_d = chol_pkg::S_LOAD;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.wr_sel = chol_pkg::WSEL_IN;
		rd_addr  = '0;
		wr_addr  = '0;
		in_stall = 1'b1;
		case (state_q)
			chol_pkg::S_LOAD: begin
				in_stall   = 1'b0;
				cmd.wr_en  = accept && room;
				wr_addr    = load_count_q[ADDR_W-1:0];
			end
			chol_pkg::S_FILL: begin
				cmd.wr_en  = ptr_q < total;
				cmd.wr_sel = chol_pkg::WSEL_ZERO;
				wr_addr    = ptr_q[ADDR_W-1:0];
			end
			chol_pkg::S_ACC_RD: begin
				cmd.rd_en = 1'b1;
				rd_addr   = ADDR_W'(ri + int'(j_q));
			end
			chol_pkg::S_ACC_LD: cmd.ld_acc = 1'b1;
			chol_pkg::S_A_RD: begin
				cmd.rd_en = 1'b1;
				rd_addr   = ADDR_W'(ri + int'(k_q));
			end
			chol_pkg::S_B_RD: begin
				cmd.ld_a  = 1'b1;
				cmd.rd_en = 1'b1;
				rd_addr   = ADDR_W'(rj + int'(k_q));
			end
			chol_pkg::S_MUL:   cmd.mul = 1'b1;
			chol_pkg::S_SCALE: cmd.scale = 1'b1;
			chol_pkg::S_SUB:   cmd.sub = 1'b1;
			chol_pkg::S_PIVOT: begin
				if (j_q < i_q) begin
					cmd.rd_en = 1'b1;
					rd_addr   = ADDR_W'(rj + int'(j_q));
				end else if (!status.acc_nonpos) begin
					cmd.start_sqrt = 1'b1;
				end
			end
			chol_pkg::S_DIV_LD: cmd.start_div = 1'b1;
			chol_pkg::S_DIV_W: begin
				cmd.wr_en  = status.div_done;
				cmd.wr_sel = chol_pkg::WSEL_DIV;
				wr_addr    = ADDR_W'(ri + int'(j_q));
			end
			chol_pkg::S_SQRT_W: begin
				cmd.wr_en  = status.sqrt_done;
				cmd.wr_sel = chol_pkg::WSEL_SQRT;
				wr_addr    = ADDR_W'(ri + int'(i_q));
			end
			chol_pkg::S_OUT_RD: begin
				cmd.rd_en = 1'b1;
				rd_addr   = ptr_q[ADDR_W-1:0];
			end
			chol_pkg::S_OUT_LD: begin
				cmd.load_out = status.out_free;
				cmd.out_last = (ptr_q + 1'b1 == total);
			end
			chol_pkg::S_ERR: begin
				cmd.load_out = status.out_free;
				cmd.out_err  = 1'b1;
				cmd.out_last = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

### rtl/cholesky_decomposition_top.sv
`timescale 1ns / 1ps
// loading: one element a cycle; the element flagged last starts the factorisation
// factorisation: a multiply-subtract term reads both operands through the single read port,
// then multiplies, scales and subtracts; the off-diagonal divide and diagonal root are iterative units
// output: n(n+1)/2 results, each loaded once the result register is free; one flagged result on a bad pivot
// reset clears control and matrix_size (to MAX_ORDER) at once; the store needs no clearing
// depends on chol_pkg, chol_ctrl, chol_dp

module cholesky_decomposition_top #(
	parameter int MAX_ORDER = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel: matrix order
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [chol_pkg::CFG_W-1:0]         cfg_data,
	// element input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [chol_pkg::WORD_W-1:0] element_value,
	input  logic                               last_element,
	// factor output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [chol_pkg::WORD_W-1:0] factor_value,
	output logic                               not_positive_definite,
	output logic                               last_result
);

	localparam int SLOTS  = MAX_ORDER * (MAX_ORDER + 1) / 2;
	localparam int ADDR_W = SLOTS > 1 ? $clog2(SLOTS) : 1;

	chol_pkg::chol_cmd_t    cmd;
	chol_pkg::chol_status_t status;
	logic [ADDR_W-1:0]      rd_addr;
	logic [ADDR_W-1:0]      wr_addr;

	// register writes must only happen while idle (the block does not enforce this); every transfer is taken
	assign cfg_ready = 1'b1;

	// controller: sequences load, zero fill, row-by-row factorisation and result sweep
	chol_ctrl #(
		.MAX_ORDER (MAX_ORDER)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.last_element (last_element),
		.in_stall     (in_stall),
		.status       (status),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.wr_addr      (wr_addr)
	);

	// datapath: in-place triangle store plus arithmetic units and result register
	chol_dp #(
		.MAX_ORDER (MAX_ORDER)
	) u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.rd_addr               (rd_addr),
		.wr_addr               (wr_addr),
		.element_value         (element_value),
		.out_stall             (out_stall),
		.status                (status),
		.out_valid             (out_valid),
		.factor_value          (factor_value),
		.not_positive_definite (not_positive_definite),
		.last_result           (last_result)
	);

endmodule

### rtl/chol_checker.sv
`timescale 1ns / 1ps
// port-level checks on the cholesky block, bound to the top level
// depends on cholesky_decomposition_top ports only

module chol_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] factor_value,
	input logic        not_positive_definite,
	input logic        last_result
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(factor_value))
		else $error("stalled result changed");

	// an error result ends the run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_positive_definite |-> last_result)
		else $error("error result without last");

	// an error result carries a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_positive_definite |-> factor_value == 32'd0)
		else $error("error result with nonzero value");

	// while input is taken, any result still on the output is the run's final one
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && out_valid |-> last_result)
		else $error("input taken mid-run");

endmodule

bind cholesky_decomposition_top chol_checker u_chk (.*);

### sim/cholesky_decomposition_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for cholesky_decomposition_top: clocked driver and monitor,
// bit-exact Q16.16 factor predictor, matrix_size reconfigured between phases
// depends on chol_pkg and the cholesky_decomposition_top rtl

module cholesky_decomposition_top_tb;

	localparam int WORD_W    = chol_pkg::WORD_W;
	localparam int FRAC_W    = chol_pkg::FRAC_W;
	localparam int CFG_W     = chol_pkg::CFG_W;
	localparam int ORDER_MAX = 8;
	localparam int SLOTS     = ORDER_MAX * (ORDER_MAX + 1) / 2;
	localparam int ITEM_GOAL = 450;

	// kinds of generated matrix
	typedef enum int {
		MAT_SPD, MAT_NOISE, MAT_SHORT, MAT_LONG, MAT_NONPOS
	} mat_kind_t;

	typedef struct {
		logic signed [WORD_W-1:0] value;
		logic                     last;
	} element_t;

	typedef struct {
		logic signed [WORD_W-1:0] value;
		logic                     err;
		logic                     last;
	} factor_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_W-1:0]         cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [WORD_W-1:0] element_value;
	logic                     last_element;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [WORD_W-1:0] factor_value;
	logic                     not_positive_definite;
	logic                     last_result;

	cholesky_decomposition_top #(.MAX_ORDER(ORDER_MAX)) u_dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cfg_valid             (cfg_valid),
		.cfg_ready             (cfg_ready),
		.cfg_data              (cfg_data),
		.in_valid              (in_valid),
		.in_stall              (in_stall),
		.element_value         (element_value),
		.last_element          (last_element),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.factor_value          (factor_value),
		.not_positive_definite (not_positive_definite),
		.last_result           (last_result)
	);

	// elements waiting to be sent, factor results still owed by the block
	element_t pending_q[$];
	factor_t  factor_q[$];

	// predictor state: private copy of the triangle, fill count and order register
	logic signed [WORD_W-1:0] tri_mem [SLOTS];
	int unsigned              fill_count;
	logic [CFG_W-1:0]         order_reg;

	int  fail_count;
	int  items_sent;
	int  runs_done;
	int  factors_seen;
	int  pivot_errors;
	bit  send_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#20ms;
		$display("FAIL cholesky_decomposition_top");
		$finish;
	end

	// ---------------------------------------------------------------- arithmetic

	function automatic logic signed [WORD_W-1:0] clamp32(input longint v);
		if (v > longint'(32'sh7fffffff))
			return 32'sh7fffffff;
		if (v < -longint'(64'sd2147483648))
			return 32'sh80000000;
		return v[WORD_W-1:0];
	endfunction

	// q16.16 product, truncated toward zero then saturated
	function automatic logic signed [WORD_W-1:0] q_mul(input logic signed [WORD_W-1:0] a,
			input logic signed [WORD_W-1:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return clamp32(p / 65536);
	endfunction

	function automatic logic signed [WORD_W-1:0] q_div(input logic signed [WORD_W-1:0] num,
			input logic signed [WORD_W-1:0] den);
		if (den <= 0)
			return '0;
		return clamp32((longint'(num) * 65536) / longint'(den));
	endfunction

	// bitwise integer root of v * 2^16, floor
	function automatic logic signed [WORD_W-1:0] q_sqrt(input logic signed [WORD_W-1:0] v);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] bitv;
		if (v <= 0)
			return '0;
		x    = {32'd0, v} << FRAC_W;
		res  = '0;
		bitv = 64'd1 << 46;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x   = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res[WORD_W-1:0];
	endfunction

	// ---------------------------------------------------------------- predictor

	// one accepted element: store it and, on the last flag, factor and queue L
	task automatic factor_element(input logic signed [WORD_W-1:0] v, input logic last);
		int unsigned n;
		int unsigned total;
		int unsigned ri;
		int unsigned rj;
		logic signed [WORD_W-1:0] acc;
		factor_t f;
		bit aborted;
		if (fill_count < SLOTS) begin
			tri_mem[fill_count] = v;
			fill_count++;
		end
		if (!last)
			return;
		n = order_reg;
		if (n < 1)
			n = 1;
		if (n > ORDER_MAX)
			n = ORDER_MAX;
		total = n * (n + 1) / 2;
		// missing elements count as zero
		for (int unsigned i = fill_count; i < total; i++)
			tri_mem[i] = '0;
		fill_count = 0;
		aborted = 1'b0;
		runs_done++;
		for (int unsigned i = 0; i < n && !aborted; i++) begin
			ri = i * (i + 1) / 2;
			for (int unsigned j = 0; j <= i && !aborted; j++) begin
				acc = tri_mem[ri + j];
				rj  = j * (j + 1) / 2;
				for (int unsigned k = 0; k < j; k++)
					acc = clamp32(longint'(acc) - longint'(q_mul(tri_mem[ri + k], tri_mem[rj + k])));
				if (j < i) begin
					tri_mem[ri + j] = q_div(acc, tri_mem[rj + j]);
				end else if (acc <= 0) begin
					aborted = 1'b1;
				end else begin
					tri_mem[ri + i] = q_sqrt(acc);
				end
			end
		end
		if (aborted) begin
			// non-positive pivot: single flagged result
			f.value = '0;
			f.err   = 1'b1;
			f.last  = 1'b1;
			factor_q.push_back(f);
			pivot_errors++;
			return;
		end
		for (int unsigned k = 0; k < total; k++) begin
			f.value = tri_mem[k];
			f.err   = 1'b0;
			f.last  = (k + 1 == total);
			factor_q.push_back(f);
		end
	endtask

	// ---------------------------------------------------------------- driver

	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		element_t e;
		if (!arst_n) begin
			in_valid      <= 1'b0;
			element_value <= '0;
			last_element  <= 1'b0;
			burst_left    = 0;
			gap_left      = 0;
		end else begin
			// transfer on this edge feeds the predictor
			if (in_valid && !in_stall) begin
				factor_element(element_value, last_element);
				items_sent++;
			end
			// payload only moves once the current one is taken
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0 && !send_hold) begin
					e = pending_q.pop_front();
					element_value <= e.value;
					last_element  <= e.last;
					in_valid      <= 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(0, 20);
						// some bursts run straight on with no gap
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	int stall_mode;
	int stall_span;

	always @(posedge clk or negedge arst_n) begin
		factor_t f;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_mode = 0;
			stall_span = 0;
		end else begin
			if (out_valid && !out_stall) begin
				factors_seen++;
				if (factor_q.size() == 0) begin
					$error("unexpected factor transfer: value %0d err %0b last %0b",
						factor_value, not_positive_definite, last_result);
					fail_count++;
				end else begin
					f = factor_q.pop_front();
					if (factor_value !== f.value) begin
						$error("factor_value expected %0d actual %0d", f.value, factor_value);
						fail_count++;
					end
					if (not_positive_definite !== f.err) begin
						$error("not_positive_definite expected %0b actual %0b",
							f.err, not_positive_definite);
						fail_count++;
					end
					if (last_result !== f.last) begin
						$error("last_result expected %0b actual %0b", f.last, last_result);
						fail_count++;
					end
				end
			end
			// receiver pattern: free-running, light or heavy back-pressure, picked at random for each span
			if (stall_span == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_span = $urandom_range(16, 96);
			end else begin
				stall_span--;
			end
			case (stall_mode)
				0: begin
					out_stall <= 1'b0;
				end
				1: begin
					out_stall <= ($urandom_range(0, 1) == 1);
				end
				default: begin
					out_stall <= ($urandom_range(0, 9) != 0);
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic add_element(input logic signed [WORD_W-1:0] v, input logic last);
		element_t e;
		e.value = v;
		e.last  = last;
		pending_q.push_back(e);
	endtask

	// wait for the block to drain: nothing to send, nothing owed, then a short settle
	task automatic wait_drained();
		while (pending_q.size() > 0 || in_valid || factor_q.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_order(input logic [CFG_W-1:0] v);
		wait_drained();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		order_reg = v;
	endtask

	// one matrix of order n with the last flag on its final element
	task automatic add_matrix(input int n, input mat_kind_t kind);
		int count;
		int idx;
		logic signed [WORD_W-1:0] v;
		count = n * (n + 1) / 2;
		if (kind == MAT_SHORT)
			count = $urandom_range(1, count);
		if (kind == MAT_LONG)
			count = count + $urandom_range(1, 40);
		idx = 0;
		for (int i = 0; i < ORDER_MAX + 8 && idx < count; i++) begin
			for (int j = 0; j <= i && idx < count; j++) begin
				case (kind)
					MAT_NOISE: v = $urandom;
					MAT_NONPOS: v = (i == j) ? -$signed($urandom_range(0, 32'h0004_0000))
						: $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
					default: begin
						// diagonally dominant, so positive definite
						if (i == j)
							v = n * 32'sh0002_0000 + $urandom_range(1, 32'h0004_0000);
						else
							v = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
					end
				endcase
				idx++;
				add_element(v, idx == count);
			end
		end
	endtask

	initial begin
		int n;
		int pick;
		mat_kind_t kind;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		fail_count  = 0;
		items_sent  = 0;
		runs_done   = 0;
		factors_seen = 0;
		pivot_errors = 0;
		send_hold   = 1'b0;
		fill_count  = 0;
		order_reg   = CFG_W'(ORDER_MAX);
		repeat (12) @(posedge clk);
		arst_n = 1'b1;

		// directed: reset order of 8, a well-formed full matrix
		add_matrix(ORDER_MAX, MAT_SPD);
		// order 1: zero pivot, most negative, largest positive
		write_order(4'd1);
		add_element(32'sh0000_0000, 1'b1);
		add_element(32'sh8000_0000, 1'b1);
		add_element(32'sh7fff_ffff, 1'b1);
		// order 0 clamps to 1; order 15 clamps to the maximum
		write_order(4'd0);
		add_element(32'sh0001_0000, 1'b1);
		// order 2: tiny pivot with huge off-diagonal saturates the divide
		write_order(4'd2);
		add_element(32'sh0000_0001, 1'b0);
		add_element(32'sh7fff_ffff, 1'b0);
		add_element(32'sh7fff_ffff, 1'b1);
		// second pivot goes negative
		add_element(32'sh0001_0000, 1'b0);
		add_element(32'sh8000_0000, 1'b0);
		add_element(32'sh0001_0000, 1'b1);
		// too few elements: missing ones read as zero
		add_element(32'sh0004_0000, 1'b1);
		write_order(4'd15);
		add_matrix(ORDER_MAX, MAT_LONG);
		// pause the sender until the block has caught up
		wait_drained();

		// random phases: mostly well-formed, some broken or noisy
		while (items_sent + pending_q.size() < ITEM_GOAL) begin
			pick = $urandom_range(0, 9);
			n = (pick == 0) ? ORDER_MAX : $urandom_range(1, 4);
			if ($urandom_range(0, 7) == 0)
				n = $urandom_range(9, 15);
			write_order(CFG_W'(n));
			if (n > ORDER_MAX)
				n = ORDER_MAX;
			for (int r = $urandom_range(1, 3); r > 0; r--) begin
				pick = $urandom_range(0, 19);
				if (pick < 13)
					kind = MAT_SPD;
				else if (pick < 15)
					kind = MAT_NOISE;
				else if (pick < 17)
					kind = MAT_NONPOS;
				else if (pick < 18)
					kind = MAT_SHORT;
				else
					kind = MAT_LONG;
				add_matrix(n, kind);
			end
		end

		wait_drained();
		repeat (200) @(posedge clk);
		$display("covered %0d elements over %0d factorisations, %0d factor transfers, %0d pivot aborts",
			items_sent, runs_done, factors_seen, pivot_errors);
		$display("orders 0 to 15 written, noise, short, long and non-positive matrices included");
		if (fail_count == 0 && factor_q.size() == 0)
			$display("PASS cholesky_decomposition_top");
		else
			$display("FAIL cholesky_decomposition_top");
		$finish;
	end

endmodule
